FILE: sv/ittf_pkg.sv
package ittf_pkg;

   // Field and counter widths
   localparam int VALUE_W = 64;
   localparam int LEN_W   = 7;
   localparam int DIGIT_W = 4;

   // Radix codes; any other code selects hexadecimal
   localparam logic [1:0] RADIX_OCT = 2'd0;
   localparam logic [1:0] RADIX_DEC = 2'd1;

   // ASCII codes
   localparam logic [6:0] CH_SPACE = 7'h20;
   localparam logic [6:0] CH_ZERO  = 7'h30;
   localparam logic [6:0] CH_MINUS = 7'h2D;
   localparam logic [6:0] CH_PLUS  = 7'h2B;
   localparam logic [6:0] CH_X     = 7'h58;
   localparam logic [6:0] CH_A     = 7'h41;
   localparam logic [6:0] CASE_BIT = 7'h20;

   typedef struct packed {
      logic [1:0]       radix;
      logic             is_signed;
      logic             lowercase;
      logic             alt_form;
      logic             plus_sign;
      logic             zero_pad;
      logic             left_justify;
      logic [LEN_W-1:0] field_width;
      logic             has_precision;
      logic [5:0]       precision;
      logic             negative;
   } fmt_type;

   typedef struct packed {
      logic busy;
      logic done;
   } stat_type;

   // Half of the number base: a digit at or above it carries on doubling
   function automatic logic [DIGIT_W-1:0] half_base(input logic [1:0] radix);
      logic [DIGIT_W-1:0] half;
      case (radix)
         RADIX_OCT: half = 4'd4;
         RADIX_DEC: half = 4'd5;
         default:   half = 4'd8;
      endcase
      return half;
   endfunction

   // ASCII for one digit, letters lowered on request
   function automatic logic [6:0] digit_char(input logic [DIGIT_W-1:0] d,
                                             input logic lc);
      logic [6:0] ch;
      if (d < 4'd10) begin
         ch = CH_ZERO + {3'b000, d};
      end else begin
         ch = (CH_A + {3'b000, d} - 7'd10) | (lc ? CASE_BIT : 7'd0);
      end
      return ch;
   endfunction

endpackage

FILE: sv/integer_to_text_formatter_top.sv
// Formats one 64-bit integer per request as printf-style ASCII text, one
// character per response, with rsp_last on the final character. A request
// is converted bit-serially: the magnitude is shifted, one bit a cycle,
// into a row of base-8/10/16 digit slots; the output stage then lays out
// the field, of up to MAX_WIDTH characters, and the characters follow one
// per cycle while rsp_stall lets them through. A new request is taken once
// the previous field has been handed to the output register; the last
// character may still wait there. A request whose field is empty
// (zero with precision zero and no prefix, sign or width) gives no
// response at all.
module integer_to_text_formatter_top #(
   parameter int MAX_WIDTH   = 64,
   parameter int DIGIT_SLOTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_value,
   input  logic [1:0]  req_radix,
   input  logic        req_is_signed,
   input  logic        req_lowercase,
   input  logic        req_alt_form,
   input  logic        req_plus_sign,
   input  logic        req_zero_pad,
   input  logic        req_left_justify,
   input  logic [6:0]  req_field_width,
   input  logic        req_has_precision,
   input  logic [5:0]  req_precision,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_character,
   output logic        rsp_last
);

   localparam int NDW = $clog2(DIGIT_SLOTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type                                     state_ff, state_in;
   ittf_pkg::fmt_type                             fmt_ff, fmt_in;
   ittf_pkg::stat_type                            cv_stat, em_stat;
   logic                                          accept, negative, emit_start;
   logic [63:0]                                   magnitude;
   logic [NDW-1:0]                                nd;
   logic [DIGIT_SLOTS-1:0][ittf_pkg::DIGIT_W-1:0] digits;

   // Take a request and form its magnitude
   always_comb begin
      accept    = req_valid && !req_stall;
      negative  = req_radix == ittf_pkg::RADIX_DEC && req_is_signed && req_value[63];
      magnitude = negative ? (~req_value + 64'd1) : req_value;
      fmt_in    = fmt_ff;
      if (accept) begin
         fmt_in.radix         = req_radix;
         fmt_in.is_signed     = req_is_signed;
         fmt_in.lowercase     = req_lowercase;
         fmt_in.alt_form      = req_alt_form;
         fmt_in.plus_sign     = req_plus_sign;
         fmt_in.zero_pad      = req_zero_pad;
         fmt_in.left_justify  = req_left_justify;
         fmt_in.field_width   = req_field_width;
         fmt_in.has_precision = req_has_precision;
         fmt_in.precision     = req_precision;
         fmt_in.negative      = negative;
      end
   end

   // Advance through conversion and output
   always_comb begin
      state_in   = state_ff;
      emit_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (cv_stat.done) begin
               state_in   = ST_EMIT;
               emit_start = 1'b1;
            end
         end
         ST_EMIT: begin
            if (em_stat.done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      fmt_ff <= fmt_in;
   end

   assign req_stall = state_ff != ST_IDLE;

   ittf_convert #(
      .DIGIT_SLOTS(DIGIT_SLOTS)
   ) u_convert (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .magnitude (magnitude),
      .radix     (req_radix),
      .stat      (cv_stat),
      .nd        (nd),
      .digits    (digits)
   );

   ittf_emit #(
      .MAX_WIDTH  (MAX_WIDTH),
      .DIGIT_SLOTS(DIGIT_SLOTS)
   ) u_emit (
      .clock         (clock),
      .reset         (reset),
      .start         (emit_start),
      .fmt           (fmt_ff),
      .nd            (nd),
      .digits        (digits),
      .stat          (em_stat),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   a_conv_done_in_conv: assert property (@(posedge clock) disable iff (reset)
      cv_stat.done |-> state_ff == ST_CONV)
      else $error("conversion finished outside the conversion phase");

   a_emit_done_in_emit: assert property (@(posedge clock) disable iff (reset)
      em_stat.done |-> state_ff == ST_EMIT && !cv_stat.busy)
      else $error("output finished outside the output phase");

endmodule

FILE: sv/ittf_convert.sv
module ittf_convert #(
   parameter int  DIGIT_SLOTS = 32,
   localparam int IDXW        = $clog2(DIGIT_SLOTS),
   localparam int NDW         = $clog2(DIGIT_SLOTS + 1)
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic [ittf_pkg::VALUE_W-1:0]              magnitude,
   input  logic [1:0]                                radix,
   output ittf_pkg::stat_type                        stat,
   output logic [NDW-1:0]                            nd,
   output logic [DIGIT_SLOTS-1:0][ittf_pkg::DIGIT_W-1:0] digits
);

   localparam int CNTW = $clog2(ittf_pkg::VALUE_W);
   localparam logic [CNTW-1:0] CNT_LAST = CNTW'(ittf_pkg::VALUE_W - 1);

   logic                                          busy_ff, busy_in;
   logic                                          done_ff, done_in;
   logic [CNTW-1:0]                               cnt_ff, cnt_in;
   logic [ittf_pkg::VALUE_W-1:0]                  val_ff, val_in;
   logic [1:0]                                    radix_ff, radix_in;
   logic [DIGIT_SLOTS-1:0][ittf_pkg::DIGIT_W-1:0] digit_ff, digit_in, digit_step;
   logic [NDW-1:0]                                nd_ff, nd_in, nd_m1;
   logic [ittf_pkg::DIGIT_W-1:0]                  half;
   logic [DIGIT_SLOTS-1:0]                        carry, cin;
   logic [ittf_pkg::DIGIT_W-1:0]                  reduced;
   logic                                          top_carry;

   // Double every digit slot and shift in the next value bit, base-aware
   always_comb begin
      half = ittf_pkg::half_base(radix_ff);
      for (int i = 0; i < DIGIT_SLOTS; i++) begin
         carry[i] = digit_ff[i] >= half;
      end
      cin = {carry[DIGIT_SLOTS-2:0], val_ff[ittf_pkg::VALUE_W-1]};
      for (int i = 0; i < DIGIT_SLOTS; i++) begin
         reduced       = digit_ff[i] - (carry[i] ? half : 4'd0);
         digit_step[i] = {reduced[2:0], cin[i]};
      end
      nd_m1     = nd_ff - NDW'(1);
      top_carry = carry[nd_m1[IDXW-1:0]];
   end

   // Sequence the conversion, one value bit per cycle
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      val_in   = val_ff;
      radix_in = radix_ff;
      digit_in = digit_ff;
      nd_in    = nd_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         val_in   = magnitude;
         radix_in = radix;
         digit_in = '0;
         nd_in    = '0;
      end else if (busy_ff) begin
         cnt_in   = cnt_ff + CNTW'(1);
         val_in   = {val_ff[ittf_pkg::VALUE_W-2:0], 1'b0};
         digit_in = digit_step;
         // track the count of significant digits
         if (nd_ff == '0) begin
            nd_in = NDW'(val_ff[ittf_pkg::VALUE_W-1]);
         end else if (top_carry && nd_ff < NDW'(DIGIT_SLOTS)) begin
            nd_in = nd_ff + NDW'(1);
         end
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      val_ff   <= val_in;
      radix_ff <= radix_in;
      digit_ff <= digit_in;
      nd_ff    <= nd_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign nd        = nd_ff;
   assign digits    = digit_ff;

   a_nd_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> nd_ff <= NDW'(DIGIT_SLOTS))
      else $error("digit count beyond digit slots");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("conversion done without a preceding run");

endmodule

FILE: sv/ittf_emit.sv
module ittf_emit #(
   parameter int  MAX_WIDTH   = 64,
   parameter int  DIGIT_SLOTS = 32,
   localparam int IDXW        = $clog2(DIGIT_SLOTS),
   localparam int NDW         = $clog2(DIGIT_SLOTS + 1)
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          start,
   input  ittf_pkg::fmt_type                             fmt,
   input  logic [NDW-1:0]                                nd,
   input  logic [DIGIT_SLOTS-1:0][ittf_pkg::DIGIT_W-1:0] digits,
   output ittf_pkg::stat_type                            stat,
   output logic                                          rsp_valid,
   input  logic                                          rsp_stall,
   output logic [6:0]                                    rsp_character,
   output logic                                          rsp_last
);

   localparam int W = ittf_pkg::LEN_W;
   localparam logic [W-1:0] MAX_LEN = W'(MAX_WIDTH);

   typedef enum logic [2:0] {
      EM_IDLE   = 3'b001,
      EM_LAYOUT = 3'b010,
      EM_SEND   = 3'b100
   } em_state_type;

   em_state_type state_ff, state_in;
   logic         done_ff, done_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [6:0]   rsp_character_ff, rsp_character_in;
   logic         rsp_last_ff, rsp_last_in;
   logic [W-1:0] pos_ff, pos_in;
   logic [W-1:0] full_ff, full_in;
   logic [W-1:0] b1_ff, b1_in, b2_ff, b2_in, b3_ff, b3_in, b4_ff, b4_in;
   logic [6:0]   pre0_ff, pre0_in, pre1_ff, pre1_in;

   // layout terms
   logic [1:0]   plen;
   logic [6:0]   pre0, pre1;
   logic [W-1:0] plen_w, room, prec_w, prec_sat, ndig, width_sat;
   logic [W-1:0] head, zeros, numlen, full, pad, b1;

   // character selection
   logic [W-1:0]                 dix_full;
   logic [IDXW-1:0]              dix;
   logic [6:0]                   ch;
   logic                         is_last, out_free;

   // Work out prefix, digit count, zero fill and padding of the field
   always_comb begin
      plen = 2'd0;
      pre0 = ittf_pkg::CH_ZERO;
      pre1 = ittf_pkg::CH_X | (fmt.lowercase ? ittf_pkg::CASE_BIT : 7'd0);
      if (fmt.radix != ittf_pkg::RADIX_DEC) begin
         if (fmt.alt_form) begin
            plen = (fmt.radix == ittf_pkg::RADIX_OCT) ? 2'd1 : 2'd2;
         end
      end else if (fmt.negative) begin
         plen = 2'd1;
         pre0 = ittf_pkg::CH_MINUS;
      end else if (fmt.is_signed && fmt.plus_sign) begin
         plen = 2'd1;
         pre0 = ittf_pkg::CH_PLUS;
      end
      plen_w    = W'(plen);
      room      = MAX_LEN - plen_w;
      prec_w    = W'(fmt.precision);
      prec_sat  = (fmt.has_precision && prec_w > room) ? room : prec_w;
      width_sat = (fmt.field_width > MAX_LEN) ? MAX_LEN : fmt.field_width;
      if (nd == '0) begin
         ndig = (fmt.has_precision && fmt.precision == '0) ? W'(0) : W'(1);
      end else begin
         ndig = W'(nd);
      end
      head  = plen_w + ndig;
      zeros = '0;
      if (fmt.has_precision) begin
         if (prec_sat > ndig) begin
            zeros = prec_sat - ndig;
         end
      end else if (fmt.zero_pad && !fmt.left_justify && width_sat > head) begin
         zeros = width_sat - head;
      end
      numlen = head + zeros;
      full   = (numlen > width_sat) ? numlen : width_sat;
      pad    = full - numlen;
      b1     = fmt.left_justify ? W'(0) : pad;
   end

   // Pick the character at the current position
   always_comb begin
      dix_full = b4_ff - W'(1) - pos_ff;
      dix      = dix_full[IDXW-1:0];
      if (pos_ff < b1_ff) begin
         ch = ittf_pkg::CH_SPACE;
      end else if (pos_ff < b2_ff) begin
         ch = (pos_ff == b1_ff) ? pre0_ff : pre1_ff;
      end else if (pos_ff < b3_ff) begin
         ch = ittf_pkg::CH_ZERO;
      end else if (pos_ff < b4_ff) begin
         ch = ittf_pkg::digit_char(digits[dix], fmt.lowercase);
      end else begin
         ch = ittf_pkg::CH_SPACE;
      end
      is_last  = pos_ff == full_ff - W'(1);
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   // Sequence layout and character output
   always_comb begin
      state_in         = state_ff;
      done_in          = 1'b0;
      pos_in           = pos_ff;
      full_in          = full_ff;
      b1_in            = b1_ff;
      b2_in            = b2_ff;
      b3_in            = b3_ff;
      b4_in            = b4_ff;
      pre0_in          = pre0_ff;
      pre1_in          = pre1_ff;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      case (state_ff)
         EM_IDLE: begin
            if (start) begin
               state_in = EM_LAYOUT;
            end
         end
         EM_LAYOUT: begin
            pos_in  = '0;
            full_in = full;
            b1_in   = b1;
            b2_in   = b1 + plen_w;
            b3_in   = b1 + plen_w + zeros;
            b4_in   = b1 + numlen;
            pre0_in = pre0;
            pre1_in = pre1;
            // an empty field ends here
            if (full == '0) begin
               state_in = EM_IDLE;
               done_in  = 1'b1;
            end else begin
               state_in = EM_SEND;
            end
         end
         EM_SEND: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = ch;
               rsp_last_in      = is_last;
               pos_in           = pos_ff + W'(1);
               if (is_last) begin
                  state_in = EM_IDLE;
                  done_in  = 1'b1;
               end
            end
         end
         default: begin
            state_in = EM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= EM_IDLE;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff           <= pos_in;
      full_ff          <= full_in;
      b1_ff            <= b1_in;
      b2_ff            <= b2_in;
      b3_ff            <= b3_in;
      b4_ff            <= b4_in;
      pre0_ff          <= pre0_in;
      pre1_ff          <= pre1_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign stat.busy     = state_ff != EM_IDLE;
   assign stat.done     = done_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

   a_pos_in_field: assert property (@(posedge clock) disable iff (reset)
      state_ff == EM_SEND |-> pos_ff < full_ff && full_ff <= MAX_LEN)
      else $error("character position outside the field");

   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      done_ff && $past(state_ff) == EM_SEND |-> rsp_valid_ff && rsp_last_ff)
      else $error("field finished without a last character");

endmodule

FILE: verif/integer_to_text_formatter_checker.sv
`timescale 1ns / 1ps

module integer_to_text_formatter_checker #(
   parameter int MAX_WIDTH   = 64,
   parameter int DIGIT_SLOTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [63:0] req_value,
   input  logic [1:0]  req_radix,
   input  logic        req_is_signed,
   input  logic        req_lowercase,
   input  logic        req_alt_form,
   input  logic        req_plus_sign,
   input  logic        req_zero_pad,
   input  logic        req_left_justify,
   input  logic [6:0]  req_field_width,
   input  logic        req_has_precision,
   input  logic [5:0]  req_precision,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [6:0]  rsp_character,
   input  logic        rsp_last,
   output int          mismatch_count,
   output int          pending_count
);

   // Digit glyphs, most significant byte first
   localparam logic [127:0] DIGIT_GLYPHS = "0123456789ABCDEF";

   // Characters still owed by the block, oldest first
   logic [6:0] text_chars [$];
   logic       text_last  [$];
   int         failures = 0;

   // Lay out one formatted number and queue its characters
   function automatic void format_number_text(
      input logic [63:0] value,
      input logic [1:0]  radix,
      input logic        is_signed,
      input logic        lowercase,
      input logic        alt_form,
      input logic        plus_sign,
      input logic        zero_pad,
      input logic        left_justify,
      input logic [6:0]  field_width,
      input logic        has_precision,
      input logic [5:0]  precision
   );
      logic [63:0] mag;
      logic [63:0] base;
      logic [3:0]  digit;
      logic [6:0]  case_mask;
      logic [6:0]  prefix [2];
      logic [6:0]  digits [DIGIT_SLOTS];
      logic [6:0]  text [$];
      int          width;
      int          prec;
      int          plen;
      int          ndig;
      int          zeros;
      int          numlen;
      int          full;
      int          pad;
      int          k;

      mag       = value;
      case_mask = lowercase ? ittf_pkg::CASE_BIT : 7'd0;
      width     = (int'(field_width) > MAX_WIDTH) ? MAX_WIDTH : int'(field_width);
      prec      = int'(precision);
      plen      = 0;
      ndig      = 0;
      zeros     = 0;
      if (radix == ittf_pkg::RADIX_OCT) begin
         base = 64'd8;
      end else if (radix == ittf_pkg::RADIX_DEC) begin
         base = 64'd10;
      end else begin
         base = 64'd16;
      end

      // Prefix for octal and hex, sign for signed decimal
      if (base != 64'd10) begin
         if (alt_form) begin
            prefix[plen] = ittf_pkg::CH_ZERO;
            plen = plen + 1;
            if (base == 64'd16) begin
               prefix[plen] = ittf_pkg::CH_X | case_mask;
               plen = plen + 1;
            end
         end
      end else if (is_signed) begin
         if (mag[63]) begin
            prefix[plen] = ittf_pkg::CH_MINUS;
            plen = plen + 1;
            mag = -mag;
         end else if (plus_sign) begin
            prefix[plen] = ittf_pkg::CH_PLUS;
            plen = plen + 1;
         end
      end

      // Clamp precision so sign or prefix plus digits fit
      if (has_precision && prec > MAX_WIDTH - plen) begin
         prec = MAX_WIDTH - plen;
      end

      // Collect digits, least significant first
      if (mag == 64'd0) begin
         if (!(has_precision && prec == 0)) begin
            digits[ndig] = ittf_pkg::CH_ZERO;
            ndig = ndig + 1;
         end
      end else begin
         while (mag != 64'd0 && ndig < DIGIT_SLOTS) begin
            digit = 4'(mag % base);
            digits[ndig] = DIGIT_GLYPHS[(15 - int'(digit)) * 8 +: 7] | case_mask;
            ndig = ndig + 1;
            mag = mag / base;
         end
      end

      // Leading zeros from precision, else from zero padding
      if (has_precision) begin
         zeros = (prec > ndig) ? prec - ndig : 0;
      end else if (zero_pad && !left_justify && width > plen + ndig) begin
         zeros = width - plen - ndig;
      end

      numlen = plen + zeros + ndig;
      full   = (numlen > width) ? numlen : width;
      pad    = full - numlen;

      if (!left_justify) begin
         for (k = 0; k < pad; k++) text.push_back(ittf_pkg::CH_SPACE);
      end
      for (k = 0; k < plen; k++) text.push_back(prefix[k]);
      for (k = 0; k < zeros; k++) text.push_back(ittf_pkg::CH_ZERO);
      for (k = ndig; k > 0; k--) text.push_back(digits[k - 1]);
      if (left_justify) begin
         for (k = 0; k < pad; k++) text.push_back(ittf_pkg::CH_SPACE);
      end

      for (k = 0; k < text.size(); k++) begin
         text_chars.push_back(text[k]);
         text_last.push_back(k == text.size() - 1);
      end
   endfunction

   // Predict on each accepted request, compare each accepted character
   always @(posedge clock) begin : watch
      logic [6:0] want_char;
      logic       want_last;

      if (!reset) begin
         if (req_valid && !req_stall) begin
            format_number_text(req_value, req_radix, req_is_signed, req_lowercase,
                               req_alt_form, req_plus_sign, req_zero_pad,
                               req_left_justify, req_field_width,
                               req_has_precision, req_precision);
         end
         if (rsp_valid && !rsp_stall) begin
            if (text_chars.size() == 0) begin
               $error("character %h (last %b) with no request outstanding",
                      rsp_character, rsp_last);
               failures = failures + 1;
            end else begin
               want_char = text_chars.pop_front();
               want_last = text_last.pop_front();
               if (rsp_character !== want_char) begin
                  $error("character: expected %h, actual %h", want_char, rsp_character);
                  failures = failures + 1;
               end
               if (rsp_last !== want_last) begin
                  $error("last: expected %b, actual %b", want_last, rsp_last);
                  failures = failures + 1;
               end
            end
         end
      end
      mismatch_count <= failures;
      pending_count  <= text_chars.size();
   end

endmodule

FILE: verif/integer_to_text_formatter_top_test.sv
`timescale 1ns / 1ps

module integer_to_text_formatter_top_test;

   localparam int RANDOM_REQUESTS = 310;
   localparam int HOLD_AT         = 70;
   localparam int DRAIN_AT        = 190;
   localparam int LONG_HOLD       = 400;
   localparam int SETTLE_CYCLES   = 200;
   localparam int WATCHDOG_LIMIT  = 3000;

   // Radix codes; hex has no code of its own in the package, both upper codes select it
   localparam logic [1:0] RADIX_OCT     = ittf_pkg::RADIX_OCT;
   localparam logic [1:0] RADIX_DEC     = ittf_pkg::RADIX_DEC;
   localparam logic [1:0] RADIX_HEX     = 2'd2;
   localparam logic [1:0] RADIX_HEX_DUP = 2'd3;

   // Flag values for directed requests
   localparam logic OFF = 1'b0;
   localparam logic ON  = 1'b1;

   typedef struct {
      logic [63:0] value;
      logic [1:0]  radix;
      logic        is_signed;
      logic        lowercase;
      logic        alt_form;
      logic        plus_sign;
      logic        zero_pad;
      logic        left_justify;
      logic [6:0]  field_width;
      logic        has_precision;
      logic [5:0]  precision;
   } number_request_type;

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_stall;
   logic [63:0] req_value         = '0;
   logic [1:0]  req_radix         = '0;
   logic        req_is_signed     = 1'b0;
   logic        req_lowercase     = 1'b0;
   logic        req_alt_form      = 1'b0;
   logic        req_plus_sign     = 1'b0;
   logic        req_zero_pad      = 1'b0;
   logic        req_left_justify  = 1'b0;
   logic [6:0]  req_field_width   = '0;
   logic        req_has_precision = 1'b0;
   logic [5:0]  req_precision     = '0;
   logic        rsp_valid;
   logic        rsp_stall         = 1'b0;
   logic [6:0]  rsp_character;
   logic        rsp_last;

   int          mismatch_count;
   int          pending_count;
   int          quiet_cycles      = 0;
   logic        hold_request      = 1'b0;

   always #5 clock = ~clock;

   integer_to_text_formatter_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_value         (req_value),
      .req_radix         (req_radix),
      .req_is_signed     (req_is_signed),
      .req_lowercase     (req_lowercase),
      .req_alt_form      (req_alt_form),
      .req_plus_sign     (req_plus_sign),
      .req_zero_pad      (req_zero_pad),
      .req_left_justify  (req_left_justify),
      .req_field_width   (req_field_width),
      .req_has_precision (req_has_precision),
      .req_precision     (req_precision),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_character     (rsp_character),
      .rsp_last          (rsp_last)
   );

   integer_to_text_formatter_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_value         (req_value),
      .req_radix         (req_radix),
      .req_is_signed     (req_is_signed),
      .req_lowercase     (req_lowercase),
      .req_alt_form      (req_alt_form),
      .req_plus_sign     (req_plus_sign),
      .req_zero_pad      (req_zero_pad),
      .req_left_justify  (req_left_justify),
      .req_field_width   (req_field_width),
      .req_has_precision (req_has_precision),
      .req_precision     (req_precision),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_character     (rsp_character),
      .rsp_last          (rsp_last),
      .mismatch_count    (mismatch_count),
      .pending_count     (pending_count)
   );

   function automatic number_request_type make_request(
      input logic [63:0] value,
      input logic [1:0]  radix,
      input logic        is_signed,
      input logic        lowercase,
      input logic        alt_form,
      input logic        plus_sign,
      input logic        zero_pad,
      input logic        left_justify,
      input logic [6:0]  field_width,
      input logic        has_precision,
      input logic [5:0]  precision
   );
      number_request_type r;
      r.value         = value;
      r.radix         = radix;
      r.is_signed     = is_signed;
      r.lowercase     = lowercase;
      r.alt_form      = alt_form;
      r.plus_sign     = plus_sign;
      r.zero_pad      = zero_pad;
      r.left_justify  = left_justify;
      r.field_width   = field_width;
      r.has_precision = has_precision;
      r.precision     = precision;
      return r;
   endfunction

   // Mix value classes; keep most fields short to bound run time
   function automatic number_request_type random_request();
      number_request_type r;
      int                 pick;
      r.radix         = 2'($urandom_range(0, 3));
      r.is_signed     = 1'($urandom_range(0, 1));
      r.lowercase     = 1'($urandom_range(0, 1));
      r.alt_form      = 1'($urandom_range(0, 1));
      r.plus_sign     = 1'($urandom_range(0, 1));
      r.zero_pad      = 1'($urandom_range(0, 1));
      r.left_justify  = 1'($urandom_range(0, 1));
      r.has_precision = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
         0:       r.value = 64'd0;
         1:       r.value = 64'($urandom_range(1, 20));
         2:       r.value = 64'h8000_0000_0000_0000;
         3:       r.value = 64'h7FFF_FFFF_FFFF_FFFF;
         4:       r.value = -64'($urandom_range(1, 1000));
         5:       r.value = {$urandom, $urandom};
         default: r.value = {$urandom, $urandom} >> $urandom_range(0, 63);
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         r.field_width = 7'd0;
      end else if (pick < 8) begin
         r.field_width = 7'($urandom_range(1, 24));
      end else if (pick == 8) begin
         r.field_width = 7'($urandom_range(25, 64));
      end else begin
         r.field_width = 7'($urandom_range(65, 127));
      end
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
         r.precision = 6'd0;
      end else if (pick < 8) begin
         r.precision = 6'($urandom_range(1, 25));
      end else begin
         r.precision = 6'($urandom_range(26, 63));
      end
      return r;
   endfunction

   // Present one request and hold it until taken
   task automatic offer_request(input number_request_type r);
      req_valid         <= 1'b1;
      req_value         <= r.value;
      req_radix         <= r.radix;
      req_is_signed     <= r.is_signed;
      req_lowercase     <= r.lowercase;
      req_alt_form      <= r.alt_form;
      req_plus_sign     <= r.plus_sign;
      req_zero_pad      <= r.zero_pad;
      req_left_justify  <= r.left_justify;
      req_field_width   <= r.field_width;
      req_has_precision <= r.has_precision;
      req_precision     <= r.precision;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Sender: directed corner cases, then random requests in bursts
   initial begin : sender
      number_request_type plan [$];
      number_request_type r;
      int                 i;
      int                 burst_left;

      plan.push_back(make_request(64'd0, RADIX_DEC, OFF, OFF, OFF, OFF, OFF, OFF,
                                  7'd0, OFF, 6'd0));
      plan.push_back(make_request(64'd0, RADIX_DEC, OFF, OFF, OFF, OFF, OFF, OFF,
                                  7'd0, ON, 6'd0));
      plan.push_back(make_request(64'd0, RADIX_HEX, OFF, ON, ON, OFF, OFF, OFF,
                                  7'd0, ON, 6'd0));
      plan.push_back(make_request(64'd0, RADIX_OCT, OFF, OFF, ON, OFF, OFF, OFF,
                                  7'd0, ON, 6'd0));
      plan.push_back(make_request(64'd0, RADIX_DEC, ON, OFF, OFF, ON, OFF, OFF,
                                  7'd0, ON, 6'd0));
      plan.push_back(make_request(64'd0, RADIX_DEC, OFF, OFF, OFF, OFF, OFF, ON,
                                  7'd5, ON, 6'd0));
      plan.push_back(make_request('1, RADIX_DEC, OFF, OFF, OFF, OFF, OFF, OFF,
                                  7'd0, OFF, 6'd0));
      plan.push_back(make_request(64'h8000_0000_0000_0000, RADIX_DEC, ON, OFF, OFF, ON,
                                  OFF, OFF, 7'd0, OFF, 6'd0));
      plan.push_back(make_request('1, RADIX_DEC, ON, OFF, OFF, ON, ON, OFF,
                                  7'd64, OFF, 6'd0));
      plan.push_back(make_request(64'd12345, RADIX_DEC, ON, OFF, OFF, ON, OFF, OFF,
                                  7'd0, OFF, 6'd0));
      plan.push_back(make_request(64'h7FFF_FFFF_FFFF_FFFF, RADIX_DEC, ON, OFF, OFF, OFF,
                                  OFF, OFF, 7'd0, OFF, 6'd0));
      plan.push_back(make_request('1, RADIX_HEX, OFF, ON, ON, OFF, OFF, OFF,
                                  7'd0, OFF, 6'd0));
      plan.push_back(make_request(64'hDEAD_BEEF, RADIX_HEX, OFF, OFF, ON, OFF, ON, OFF,
                                  7'd20, OFF, 6'd0));
      plan.push_back(make_request(64'hABCD_EF01, RADIX_HEX_DUP, ON, OFF, OFF, ON, OFF, OFF,
                                  7'd0, OFF, 6'd0));
      plan.push_back(make_request('1, RADIX_OCT, ON, OFF, ON, ON, OFF, OFF,
                                  7'd0, OFF, 6'd0));
      plan.push_back(make_request(64'd42, RADIX_DEC, ON, OFF, OFF, ON, ON, ON,
                                  7'd10, OFF, 6'd0));
      plan.push_back(make_request(64'd42, RADIX_DEC, OFF, OFF, OFF, OFF, ON, OFF,
                                  7'd12, ON, 6'd5));
      plan.push_back(make_request(64'd7, RADIX_OCT, OFF, OFF, OFF, OFF, OFF, OFF,
                                  7'd127, OFF, 6'd0));
      plan.push_back(make_request(-64'd5, RADIX_DEC, ON, OFF, OFF, OFF, OFF, OFF,
                                  7'd0, ON, 6'd63));
      plan.push_back(make_request(64'hF, RADIX_HEX, OFF, ON, ON, OFF, OFF, OFF,
                                  7'd0, ON, 6'd63));
      plan.push_back(make_request(64'd1, RADIX_DEC, OFF, OFF, OFF, OFF, OFF, OFF,
                                  7'd0, ON, 6'd63));
      plan.push_back(make_request(64'd99, RADIX_DEC, OFF, OFF, OFF, OFF, OFF, ON,
                                  7'd64, OFF, 6'd0));
      plan.push_back(make_request(64'h8000_0000_0000_0000, RADIX_DEC, ON, OFF, OFF, OFF,
                                  ON, OFF, 7'd64, OFF, 6'd0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      burst_left = 0;

      for (i = 0; i < plan.size() + RANDOM_REQUESTS; i++) begin
         r = (i < plan.size()) ? plan[i] : random_request();
         if (i == HOLD_AT) begin
            hold_request = 1'b1;
         end
         if (i == DRAIN_AT) begin
            // pause until every owed character has come back
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
            burst_left = $urandom_range(1, 12);
         end else if (burst_left == 0) begin
            // idle between bursts
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 16);
         end
         offer_request(r);
         burst_left = burst_left - 1;
      end

      // Drain and let the block settle
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_count != 0) begin
         $error("characters still outstanding: %0d", pending_count);
      end
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("integer_to_text_formatter_top_test OK");
      end else begin
         $display("integer_to_text_formatter_top_test NOT OK");
      end
      $finish;
   end

   // Receiver: stall in random modes, with one long hold on request
   initial begin : receiver
      int mode;
      int mode_left;
      mode      = 0;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD - 1) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(16, 96);
            end
            mode_left = mode_left - 1;
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("integer_to_text_formatter_top_test NOT OK");
            $finish;
         end
      end
   end

endmodule

FILE: filelist.f
sv/ittf_pkg.sv
sv/ittf_convert.sv
sv/ittf_emit.sv
sv/integer_to_text_formatter_top.sv
verif/integer_to_text_formatter_checker.sv
verif/integer_to_text_formatter_top_test.sv
